@@ sv/ldif_pkg.sv @@
// ----------------------------------------------------------------------------
// ldif_pkg
// Types, codes and character constants shared by the LDIF line tokenizer.
// ----------------------------------------------------------------------------
package ldif_pkg;

  // parse states
  localparam logic [3:0] ST_LINE    = 4'd0;
  localparam logic [3:0] ST_CMT     = 4'd1;
  localparam logic [3:0] ST_CMT_NL  = 4'd2;
  localparam logic [3:0] ST_NAME    = 4'd3;
  localparam logic [3:0] ST_NAME_NL = 4'd4;
  localparam logic [3:0] ST_ENC     = 4'd5;
  localparam logic [3:0] ST_ENC_NL  = 4'd6;
  localparam logic [3:0] ST_VAL     = 4'd7;
  localparam logic [3:0] ST_VAL_NL  = 4'd8;
  localparam logic [3:0] ST_CR      = 4'd9;
  localparam logic [3:0] ST_ERR     = 4'd10;

  // where to go after CR LF
  localparam logic [2:0] RS_LINE = 3'd0;
  localparam logic [2:0] RS_CMT  = 3'd1;
  localparam logic [2:0] RS_NAME = 3'd2;
  localparam logic [2:0] RS_ENC  = 3'd3;
  localparam logic [2:0] RS_VAL  = 3'd4;

  // token kinds
  localparam logic [2:0] K_NAME  = 3'd0;
  localparam logic [2:0] K_VALUE = 3'd1;
  localparam logic [2:0] K_DONE  = 3'd2;
  localparam logic [2:0] K_EMPTY = 3'd3;
  localparam logic [2:0] K_END   = 3'd4;
  localparam logic [2:0] K_DASH  = 3'd5;
  localparam logic [2:0] K_ERROR = 3'd6;

  // error codes
  localparam logic [1:0] E_END  = 2'd0;
  localparam logic [1:0] E_CR   = 2'd1;
  localparam logic [1:0] E_EOL  = 2'd2;
  localparam logic [1:0] E_NULL = 2'd3;

  // value encodings
  localparam logic [1:0] ENC_PLAIN  = 2'd0;
  localparam logic [1:0] ENC_BASE64 = 2'd1;
  localparam logic [1:0] ENC_URL    = 2'd2;
  localparam logic [1:0] ENC_NONE   = 2'd3;

  // characters
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // depth of the result queue
  localparam int RES_Q_DEPTH = 4;

  typedef struct packed {
    logic [3:0] pstate;
    logic [2:0] resume;
    logic [1:0] name_len;
    logic       name_dash;
    logic [1:0] enc;
  } st_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] tbyte;
    logic [1:0] enc;
    logic [1:0] err;
    logic       last;
  } tok_t;

  localparam st_t ST_RESET = '{pstate: ST_LINE, resume: RS_LINE, name_len: 2'd0,
                               name_dash: 1'b0, enc: ENC_PLAIN};

  function automatic tok_t mk_tok(logic [2:0] kind, logic [7:0] tbyte,
                                  logic [1:0] enc, logic [1:0] err);
    tok_t t;
    t.kind  = kind;
    t.tbyte = tbyte;
    t.enc   = enc;
    t.err   = err;
    t.last  = 1'b0;
    return t;
  endfunction

endpackage

@@ sv/ldif_in_if.sv @@
// ----------------------------------------------------------------------------
// ldif_in_if
// Byte channel into the tokenizer: valid/ready with one raw text byte.
// ----------------------------------------------------------------------------
interface ldif_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

@@ sv/ldif_out_if.sv @@
// ----------------------------------------------------------------------------
// ldif_out_if
// Token channel out of the tokenizer: valid/ready with one token.
// ----------------------------------------------------------------------------
interface ldif_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] token_kind;
  logic [7:0] token_byte;
  logic [1:0] value_encoding;
  logic [1:0] error_code;
  logic       last;

  modport source (output valid, output token_kind, output token_byte,
                  output value_encoding, output error_code, output last, input ready);
  modport sink   (input valid, input token_kind, input token_byte,
                  input value_encoding, input error_code, input last, output ready);
endinterface

@@ sv/ldif_step.sv @@
// ----------------------------------------------------------------------------
// ldif_step
// Next-state and token logic for one byte or end-of-stream mark.
// ----------------------------------------------------------------------------
module ldif_step
  import ldif_pkg::*;
(
  input  st_t        st,
  input  logic [7:0] data_byte,
  input  logic       end_of_stream,
  output st_t        st_nxt,
  output logic [1:0] res_cnt,
  output tok_t       res0,
  output tok_t       res1
);

  st_t        nx;
  tok_t       res [2];
  logic [1:0] n;
  logic       do_line;
  logic       do_name;
  logic       is_dash_line;

  assign is_dash_line = st.name_dash && (st.name_len == 2'd1);

  always_comb begin
    nx      = st;
    n       = 2'd0;
    res[0]  = '0;
    res[1]  = '0;
    do_line = 1'b0;
    do_name = 1'b0;

    if (end_of_stream) begin
      case (st.pstate)
        ST_CMT, ST_NAME, ST_ENC, ST_VAL: begin
          res[n[0]] = mk_tok(K_ERROR, CH_NUL, ENC_PLAIN, E_END); n = n + 2'd1;
        end
        ST_NAME_NL: begin
          if (is_dash_line) begin
            res[n[0]] = mk_tok(K_DASH, CH_NUL, ENC_PLAIN, E_END); n = n + 2'd1;
            res[n[0]] = mk_tok(K_END, CH_NUL, ENC_PLAIN, E_END); n = n + 2'd1;
          end else begin
            res[n[0]] = mk_tok(K_ERROR, CH_NUL, ENC_PLAIN, E_EOL); n = n + 2'd1;
          end
        end
        ST_ENC_NL: begin
          res[n[0]] = mk_tok(K_DONE, CH_NUL, ENC_NONE, E_END); n = n + 2'd1;
          res[n[0]] = mk_tok(K_END, CH_NUL, ENC_PLAIN, E_END); n = n + 2'd1;
        end
        ST_VAL_NL: begin
          res[n[0]] = mk_tok(K_DONE, CH_NUL, st.enc, E_END); n = n + 2'd1;
          res[n[0]] = mk_tok(K_END, CH_NUL, ENC_PLAIN, E_END); n = n + 2'd1;
        end
        ST_CR: begin
          res[n[0]] = mk_tok(K_ERROR, CH_NUL, ENC_PLAIN, E_CR); n = n + 2'd1;
        end
        ST_ERR: ;
        default: begin
          res[n[0]] = mk_tok(K_END, CH_NUL, ENC_PLAIN, E_END); n = n + 2'd1;
        end
      endcase
      nx = ST_RESET;
    end else begin
      case (st.pstate)
        ST_CMT: begin
          if (data_byte == CH_CR) begin
            nx.pstate = ST_CR;
            nx.resume = RS_CMT;
          end else if (data_byte == CH_LF) begin
            nx.pstate = ST_CMT_NL;
          end
        end
        ST_CMT_NL: begin
          if (data_byte == CH_SP) nx.pstate = ST_CMT;
          else do_line = 1'b1;
        end
        ST_NAME: do_name = 1'b1;
        ST_NAME_NL: begin
          if (data_byte == CH_SP) begin
            nx.pstate = ST_NAME;
          end else if (is_dash_line) begin
            res[n[0]] = mk_tok(K_DASH, CH_NUL, ENC_PLAIN, E_END); n = n + 2'd1;
            do_line = 1'b1;
          end else begin
            res[n[0]] = mk_tok(K_ERROR, CH_NUL, ENC_PLAIN, E_EOL); n = n + 2'd1;
            nx.pstate = ST_ERR;
          end
        end
        ST_ENC: begin
          if (data_byte == CH_SP) begin
            nx.pstate = ST_ENC;
          end else if (data_byte == CH_COLON) begin
            nx.enc    = ENC_BASE64;
            nx.pstate = ST_VAL;
          end else if (data_byte == CH_LT) begin
            nx.enc    = ENC_URL;
            nx.pstate = ST_VAL;
          end else if (data_byte == CH_CR) begin
            nx.pstate = ST_CR;
            nx.resume = RS_ENC;
          end else if (data_byte == CH_LF) begin
            nx.pstate = ST_ENC_NL;
          end else if (data_byte == CH_NUL) begin
            res[n[0]] = mk_tok(K_ERROR, CH_NUL, ENC_PLAIN, E_NULL); n = n + 2'd1;
            nx.pstate = ST_ERR;
          end else begin
            // first byte of a plain value
            nx.enc    = ENC_PLAIN;
            nx.pstate = ST_VAL;
            res[n[0]] = mk_tok(K_VALUE, data_byte, ENC_PLAIN, E_END); n = n + 2'd1;
          end
        end
        ST_ENC_NL: begin
          if (data_byte == CH_SP) begin
            nx.pstate = ST_ENC;
          end else begin
            nx.enc = ENC_NONE;
            res[n[0]] = mk_tok(K_DONE, CH_NUL, ENC_NONE, E_END); n = n + 2'd1;
            do_line = 1'b1;
          end
        end
        ST_VAL: begin
          if (data_byte == CH_CR) begin
            nx.pstate = ST_CR;
            nx.resume = RS_VAL;
          end else if (data_byte == CH_LF) begin
            nx.pstate = ST_VAL_NL;
          end else begin
            res[n[0]] = mk_tok(K_VALUE, data_byte, st.enc, E_END); n = n + 2'd1;
          end
        end
        ST_VAL_NL: begin
          if (data_byte == CH_SP) begin
            nx.pstate = ST_VAL;
          end else begin
            res[n[0]] = mk_tok(K_DONE, CH_NUL, st.enc, E_END); n = n + 2'd1;
            do_line = 1'b1;
          end
        end
        ST_CR: begin
          if (data_byte != CH_LF) begin
            res[n[0]] = mk_tok(K_ERROR, CH_NUL, ENC_PLAIN, E_CR); n = n + 2'd1;
            nx.pstate = ST_ERR;
          end else begin
            case (st.resume)
              RS_CMT:  nx.pstate = ST_CMT_NL;
              RS_NAME: nx.pstate = ST_NAME_NL;
              RS_ENC:  nx.pstate = ST_ENC_NL;
              RS_VAL:  nx.pstate = ST_VAL_NL;
              default: begin
                res[n[0]] = mk_tok(K_EMPTY, CH_NUL, ENC_PLAIN, E_END); n = n + 2'd1;
                nx.pstate = ST_LINE;
              end
            endcase
          end
        end
        ST_ERR: ;
        default: do_line = 1'b1;
      endcase

      // byte examined as the first of a new line
      if (do_line) begin
        nx.pstate = ST_LINE;
        if (data_byte == CH_LF) begin
          res[n[0]] = mk_tok(K_EMPTY, CH_NUL, ENC_PLAIN, E_END); n = n + 2'd1;
        end else if (data_byte == CH_CR) begin
          nx.pstate = ST_CR;
          nx.resume = RS_LINE;
        end else if (data_byte == CH_HASH) begin
          nx.pstate = ST_CMT;
        end else begin
          nx.name_len  = 2'd0;
          nx.name_dash = 1'b0;
          nx.enc       = ENC_PLAIN;
          nx.pstate    = ST_NAME;
          do_name      = 1'b1;
        end
      end

      if (do_name) begin
        if (data_byte == CH_COLON) begin
          nx.pstate = ST_ENC;
        end else if (data_byte == CH_CR) begin
          nx.pstate = ST_CR;
          nx.resume = RS_NAME;
        end else if (data_byte == CH_LF) begin
          if (nx.name_len == 2'd0) begin
            res[n[0]] = mk_tok(K_ERROR, CH_NUL, ENC_PLAIN, E_EOL); n = n + 2'd1;
            nx.pstate = ST_ERR;
          end else begin
            nx.pstate = ST_NAME_NL;
          end
        end else if (data_byte == CH_NUL) begin
          res[n[0]] = mk_tok(K_ERROR, CH_NUL, ENC_PLAIN, E_NULL); n = n + 2'd1;
          nx.pstate = ST_ERR;
        end else begin
          res[n[0]] = mk_tok(K_NAME, data_byte, ENC_PLAIN, E_END); n = n + 2'd1;
          nx.name_dash = (nx.name_len == 2'd0) && (data_byte == CH_DASH);
          if (nx.name_len != 2'd3) nx.name_len = nx.name_len + 2'd1;
        end
      end
    end

    if (n == 2'd1) res[0].last = 1'b1;
    if (n == 2'd2) res[1].last = 1'b1;
  end

  assign st_nxt  = nx;
  assign res_cnt = n;
  assign res0    = res[0];
  assign res1    = res[1];

endmodule

@@ sv/ldif_line_tokenizer_unit.sv @@
// ----------------------------------------------------------------------------
// ldif_line_tokenizer_unit
// LDIF byte-stream tokenizer with a small result queue on the output side.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one item per byte of LDIF text, or an end_of_stream mark that
//            closes the stream and returns the parser to its reset state.
//   out_ch : tokens (name/value bytes, line done, empty line, dash line, end
//            of input, error); last flags the final token of an input item.
//   An input item is taken in any cycle it is offered while in_ch.ready is
//   high; its tokens (none, one or two) enter a 4-entry result queue, and
//   with the queue empty the first one is visible on out_ch in the next cycle.
//   Throughput is one item per cycle while each item yields at most one token
//   and out_ch keeps up; the single output port drains one token per cycle,
//   so the two tokens of an item that yields two leave one after the other.
//   in_ch.ready is high while the queue has room for two tokens, so a stalled
//   receiver back-pressures the input once three tokens are waiting; items
//   that yield no token are held back as well. Nothing is dropped.
//   Reset (rst_n low, synchronous) empties the queue and puts the parser at
//   the start of a line.
// ----------------------------------------------------------------------------
module ldif_line_tokenizer_unit
  import ldif_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  ldif_in_if.sink    in_ch,
  ldif_out_if.source out_ch
);

  localparam int PW = $clog2(RES_Q_DEPTH);

  st_t          st_r;
  st_t          st_nxt;
  logic [1:0]   res_cnt;
  tok_t         res0;
  tok_t         res1;

  tok_t         q_r [RES_Q_DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [PW:0]   cnt_r;
  logic [PW:0]   cnt_nxt;

  logic in_fire;
  logic out_fire;
  logic [1:0] push_cnt;

  ldif_step u_step (
    .st            (st_r),
    .data_byte     (in_ch.data_byte),
    .end_of_stream (in_ch.end_of_stream),
    .st_nxt        (st_nxt),
    .res_cnt       (res_cnt),
    .res0          (res0),
    .res1          (res1)
  );

  // room for two tokens whatever the output does this cycle
  assign in_ch.ready = (cnt_r <= (PW+1)'(RES_Q_DEPTH - 2));
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_ch.valid = (cnt_r != '0);
  assign out_fire    = out_ch.valid && out_ch.ready;
  assign push_cnt    = in_fire ? res_cnt : 2'd0;

  always_comb begin
    cnt_nxt = cnt_r + (PW+1)'(push_cnt);
    if (out_fire) cnt_nxt = cnt_nxt - (PW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_RESET;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (in_fire) st_r <= st_nxt;
      wr_ptr_r <= wr_ptr_r + PW'(push_cnt);
      if (out_fire) rd_ptr_r <= rd_ptr_r + PW'(1);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) q_r[wr_ptr_r] <= res0;
    if (push_cnt == 2'd2) q_r[wr_ptr_r + PW'(1)] <= res1;
  end

  assign out_ch.token_kind     = q_r[rd_ptr_r].kind;
  assign out_ch.token_byte     = q_r[rd_ptr_r].tbyte;
  assign out_ch.value_encoding = q_r[rd_ptr_r].enc;
  assign out_ch.error_code     = q_r[rd_ptr_r].err;
  assign out_ch.last           = q_r[rd_ptr_r].last;

endmodule
